// ===== hdl/tcw_pkg.sv =====
// shared types and constants of the text console writer
package tcw_pkg;

  localparam logic [1:0] FUNC_PUT   = 2'd0;
  localparam logic [1:0] FUNC_CLEAR = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  localparam logic [7:0] BLANK_CHAR   = 8'h20;
  localparam logic [7:0] PLAIN_ATTR   = 8'h07;
  localparam logic [7:0] NEWLINE_CODE = 8'h0A;

  localparam logic [15:0] BLANK_CELL = {PLAIN_ATTR, BLANK_CHAR};

  typedef struct packed {
    logic accept;
    logic sweep_start;
    logic blank_wr;
    logic put_step;
    logic home;
    logic read_start;
    logic scroll_step;
    logic blank_row_start;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       read_ok;
    logic       put_wraps;
    logic       ptr_last;
    logic       scroll_last;
    logic       out_free;
  } status_t;

endpackage

// ===== hdl/tcw_ram.sv =====
// generic simple dual port ram with registered read
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/tcw_ctrl.sv =====
// sequencer of the text console writer
module tcw_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  tcw_pkg::status_t status,
  output tcw_pkg::cmd_t    cmd
);

  import tcw_pkg::*;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DECODE, S_CLEAR, S_SCROLL, S_DRAIN, S_BLANK, S_READ, S_RESULT
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_INIT: begin
        cmd.blank_wr = 1'b1;
        if (status.ptr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (status.func)
          FUNC_PUT: begin
            cmd.put_step = 1'b1;
            if (status.put_wraps) begin
              cmd.sweep_start = 1'b1;
              state_next = S_SCROLL;
            end else begin
              state_next = S_RESULT;
            end
          end
          FUNC_CLEAR: begin
            cmd.home = 1'b1;
            cmd.sweep_start = 1'b1;
            state_next = S_CLEAR;
          end
          FUNC_READ: begin
            cmd.read_start = 1'b1;
            state_next = status.read_ok ? S_READ : S_RESULT;
          end
          default: state_next = S_RESULT;
        endcase
      end
      S_CLEAR: begin
        cmd.blank_wr = 1'b1;
        if (status.ptr_last) state_next = S_RESULT;
      end
      S_SCROLL: begin
        cmd.scroll_step = 1'b1;
        if (status.scroll_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        cmd.blank_row_start = 1'b1;
        state_next = S_BLANK;
      end
      S_BLANK: begin
        cmd.blank_wr = 1'b1;
        if (status.ptr_last) state_next = S_RESULT;
      end
      S_READ: state_next = S_RESULT;
      S_RESULT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      in_stall <= 1'b1;
    end else begin
      state <= state_next;
      in_stall <= (state_next != S_IDLE);
    end
  end

endmodule

// ===== hdl/tcw_dp.sv =====
// datapath of the text console writer: cursor, sweep pointer, cell store, result
module tcw_dp #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic             clk,
  input  logic             rst,
  input  tcw_pkg::cmd_t    cmd,
  output tcw_pkg::status_t status,
  input  logic [1:0]       func,
  input  logic [7:0]       char_code,
  input  logic [10:0]      cell_index,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [10:0]      cursor_pos,
  output logic [7:0]       cell_char,
  output logic [7:0]       cell_attr
);

  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
  localparam logic [AW-1:0] BOTTOM_ROW = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0] LAST_COPY  = AW'(CELLS - COLUMNS - 1);
  localparam logic [AW-1:0] COL_STEP   = AW'(COLUMNS);
  localparam logic [CW-1:0] LAST_COL   = CW'(COLUMNS - 1);

  logic [1:0]    item_func;
  logic [7:0]    item_char;
  logic [10:0]   item_index;
  logic [AW-1:0] pos;
  logic [CW-1:0] col;
  logic [AW-1:0] ptr;
  logic [AW-1:0] rd_addr;
  logic          sel_cell;
  logic          pend_valid;
  logic [AW-1:0] pend_addr;

  logic          ram_wr_en;
  logic [AW-1:0] ram_wr_addr;
  logic [15:0]   ram_wr_data;
  logic [AW-1:0] ram_rd_addr;
  logic [15:0]   ram_rd_data;
  logic          is_newline;
  logic [31:0]   pos_wide;

  assign is_newline = (item_char == NEWLINE_CODE);
  assign pos_wide   = 32'(pos);

  always_comb begin
    status.func        = item_func;
    status.read_ok     = (32'(item_index) < CELLS);
    status.put_wraps   = is_newline ? (pos >= BOTTOM_ROW) : (pos == LAST_CELL);
    status.ptr_last    = (ptr == LAST_CELL);
    status.scroll_last = (ptr == LAST_COPY);
    status.out_free    = !out_valid || !out_stall;
  end

  // one write port: pending scroll copy, blank sweep, or character put
  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = pos;
    ram_wr_data = {PLAIN_ATTR, item_char};
    if (pend_valid) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = pend_addr;
      ram_wr_data = ram_rd_data;
    end else if (cmd.blank_wr) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = ptr;
      ram_wr_data = BLANK_CELL;
    end else if (cmd.put_step && !is_newline) begin
      ram_wr_en = 1'b1;
    end
    ram_rd_addr = cmd.scroll_step ? ptr + COL_STEP : rd_addr;
  end

  tcw_ram #(.WIDTH(16), .DEPTH(CELLS)) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      col        <= '0;
      ptr        <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      pend_valid <= cmd.scroll_step;
      pend_addr  <= ptr;
      if (cmd.accept) begin
        item_func  <= func;
        item_char  <= char_code;
        item_index <= cell_index;
        sel_cell   <= 1'b0;
      end
      if (cmd.home) begin
        pos <= '0;
        col <= '0;
      end else if (cmd.put_step) begin
        if (status.put_wraps) begin
          pos <= BOTTOM_ROW;
          col <= '0;
        end else if (is_newline) begin
          pos <= pos + COL_STEP - AW'(col);
          col <= '0;
        end else begin
          pos <= pos + AW'(1);
          col <= (col == LAST_COL) ? '0 : col + CW'(1);
        end
      end
      if (cmd.sweep_start) begin
        ptr <= '0;
      end else if (cmd.blank_row_start) begin
        ptr <= BOTTOM_ROW;
      end else if (cmd.blank_wr || cmd.scroll_step) begin
        ptr <= status.ptr_last ? '0 : ptr + AW'(1);
      end
      if (cmd.read_start) begin
        rd_addr  <= AW'(item_index);
        sel_cell <= status.read_ok;
      end
      if (cmd.load_out) begin
        out_valid  <= 1'b1;
        cursor_pos <= pos_wide[10:0];
        cell_char  <= sel_cell ? ram_rd_data[7:0] : 8'h00;
        cell_attr  <= sel_cell ? ram_rd_data[15:8] : 8'h00;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst) pos <= LAST_CELL)
    else $error("cursor beyond the store");
  a_col_range: assert property (@(posedge clk) disable iff (rst) col <= LAST_COL)
    else $error("column beyond the row");
  a_wr_clash: assert property (@(posedge clk) disable iff (rst)
    !(pend_valid && (cmd.blank_wr || cmd.put_step)))
    else $error("scroll copy collides with another write");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(cursor_pos))
    else $error("stalled result lost");

endmodule

// ===== hdl/text_console_writer_top.sv =====
// top level of the text console writer
// Text console engine over a COLUMNS x ROWS store of character/attribute cells.
// Each input beat gives one result beat with the cursor position. A read of a
// cell in the store passes through an extra state for the store's registered
// read port; a clear sweeps every cell, and a put that scrolls adds the
// one-cell-a-cycle copy and bottom-row blanking through the single write port.
// After reset a clearing pass blanks the store before the first input beat is
// taken. A result beat may wait at the output while the next input beat is
// accepted.
module text_console_writer_top #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [7:0]  char_code,
  input  logic [10:0] cell_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [10:0] cursor_pos,
  output logic [7:0]  cell_char,
  output logic [7:0]  cell_attr
);

  import tcw_pkg::*;

  cmd_t    cmd;
  status_t status;

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  tcw_dp #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .func       (func),
    .char_code  (char_code),
    .cell_index (cell_index),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cursor_pos (cursor_pos),
    .cell_char  (cell_char),
    .cell_attr  (cell_attr)
  );

endmodule

// ===== verif/tb.sv =====
// testbench for text_console_writer_top: directed rows, random console traffic, shadow model check
`timescale 1ns / 1ps

module tb;
  import tcw_pkg::*;

  localparam int COLS   = 80;
  localparam int NROWS  = 25;
  localparam int CELLS  = COLS * NROWS;
  localparam int ITEMS  = 1600;
  localparam int QUIET_LIMIT = 25000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [1:0] FUNC_NONE = 2'd3;

  typedef struct packed {
    logic [10:0] pos;
    logic [7:0]  ch;
    logic [7:0]  attr;
  } report_t;

  typedef struct packed {
    logic [1:0]  f;
    logic [7:0]  c;
    logic [10:0] i;
    logic        typed;
    logic [10:0] pos;
    logic [7:0]  ch;
    logic [7:0]  attr;
  } row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  func;
  logic [7:0]  char_code;
  logic [10:0] cell_index;
  logic        out_valid;
  logic        out_stall;
  logic [10:0] cursor_pos;
  logic [7:0]  cell_char;
  logic [7:0]  cell_attr;

  logic [15:0] screen [0:CELLS-1];
  int          cursor;
  report_t     expected_reports [$];
  report_t     want;
  int          mismatches = 0;
  int          quiet = 0;
  int          burst_left = 0;
  int          beats_live = 0;
  bit          hold_req = 1'b0;
  int          hold_left = 0;
  int          stall_mode = 0;
  int          mode_left = 0;

  // reset state and typed expectations read straight off the console rules
  row_t script [0:19] = '{
    '{FUNC_READ,  8'h00, 11'd0,    1'b1, 11'd0,   BLANK_CHAR, PLAIN_ATTR},
    '{FUNC_READ,  8'hFF, 11'd1999, 1'b1, 11'd0,   BLANK_CHAR, PLAIN_ATTR},
    '{FUNC_READ,  8'h00, 11'd2000, 1'b1, 11'd0,   8'h00,      8'h00},
    '{FUNC_READ,  8'h00, 11'd2047, 1'b1, 11'd0,   8'h00,      8'h00},
    '{FUNC_NONE,  8'hFF, 11'd2047, 1'b1, 11'd0,   8'h00,      8'h00},
    '{FUNC_PUT,   8'h00, 11'd2047, 1'b1, 11'd1,   8'h00,      8'h00},
    '{FUNC_PUT,   8'hFF, 11'd0,    1'b1, 11'd2,   8'h00,      8'h00},
    '{FUNC_READ,  8'h00, 11'd0,    1'b1, 11'd2,   8'h00,      PLAIN_ATTR},
    '{FUNC_READ,  8'h00, 11'd1,    1'b1, 11'd2,   8'hFF,      PLAIN_ATTR},
    '{FUNC_PUT,   NEWLINE_CODE, 11'd0, 1'b1, 11'd80, 8'h00,   8'h00},
    '{FUNC_PUT,   NEWLINE_CODE, 11'd0, 1'b1, 11'd160, 8'h00,  8'h00},
    '{FUNC_PUT,   8'h41, 11'd0,    1'b1, 11'd161, 8'h00,      8'h00},
    '{FUNC_READ,  8'h00, 11'd160,  1'b1, 11'd161, 8'h41,      PLAIN_ATTR},
    '{FUNC_NONE,  NEWLINE_CODE, 11'd160, 1'b1, 11'd161, 8'h00, 8'h00},
    '{FUNC_CLEAR, 8'h55, 11'd1234, 1'b1, 11'd0,   8'h00,      8'h00},
    '{FUNC_READ,  8'h00, 11'd160,  1'b1, 11'd0,   BLANK_CHAR, PLAIN_ATTR},
    '{FUNC_PUT,   8'h7F, 11'd0,    1'b0, 11'd0,   8'h00,      8'h00},
    '{FUNC_PUT,   8'h80, 11'd1024, 1'b0, 11'd0,   8'h00,      8'h00},
    '{FUNC_READ,  8'h00, 11'd1,    1'b0, 11'd0,   8'h00,      8'h00},
    '{FUNC_READ,  8'h00, 11'd1024, 1'b0, 11'd0,   8'h00,      8'h00}
  };

  text_console_writer_top uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .char_code  (char_code),
    .cell_index (cell_index),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cursor_pos (cursor_pos),
    .cell_char  (cell_char),
    .cell_attr  (cell_attr)
  );

  always #5 clk = ~clk;

  task automatic blank_screen();
    int k;
    for (k = 0; k < CELLS; k++) screen[k] = BLANK_CELL;
    cursor = 0;
  endtask

  task automatic console_step(input logic [1:0] f, input logic [7:0] c, input logic [10:0] i,
                              output report_t r);
    int k;
    r = '0;
    case (f)
      FUNC_PUT: begin
        if (c == NEWLINE_CODE) begin
          cursor = cursor + COLS - (cursor % COLS);
        end else begin
          screen[cursor] = {PLAIN_ATTR, c};
          cursor++;
        end
        // scroll up one row, blank bottom row
        if (cursor >= CELLS) begin
          for (k = 0; k < CELLS - COLS; k++) screen[k] = screen[k + COLS];
          for (k = CELLS - COLS; k < CELLS; k++) screen[k] = BLANK_CELL;
          cursor = CELLS - COLS;
        end
      end
      FUNC_CLEAR: blank_screen();
      FUNC_READ: begin
        if (int'(i) < CELLS) {r.attr, r.ch} = screen[i];
      end
      default: ;
    endcase
    r.pos = cursor[10:0];
  endtask

  task automatic flag_mismatch(input string what, input int got, input int exp_val);
    $display("mismatch %s: got %0d expected %0d", what, got, exp_val);
    mismatches++;
  endtask

  task automatic issue(input logic [1:0] f, input logic [7:0] c, input logic [10:0] i,
                       input logic typed, input report_t given);
    int gap;
    report_t r;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 20);
    end
    burst_left--;
    in_valid   <= 1'b1;
    func       <= f;
    char_code  <= c;
    cell_index <= i;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    console_step(f, c, i, r);
    expected_reports.push_back(typed ? given : r);
    if (f != FUNC_NONE) beats_live++;
  endtask

  function automatic logic [10:0] recent_cell();
    return 11'((cursor + CELLS - 1 - $urandom_range(0, COLS - 1)) % CELLS);
  endfunction

  function automatic logic [10:0] any_cell();
    return ($urandom_range(0, 7) == 0) ? 11'($urandom_range(0, 2047))
                                       : 11'($urandom_range(0, CELLS - 1));
  endfunction

  // receiver: random stall modes, plus one long hold-off on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left = $urandom_range(32, 256);
        end
        mode_left--;
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // result check and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          flag_mismatch("beat with nothing pending, cursor_pos", cursor_pos, -1);
        end else begin
          want = expected_reports.pop_front();
          if (cursor_pos !== want.pos) flag_mismatch("cursor_pos", cursor_pos, want.pos);
          if (cell_char !== want.ch) flag_mismatch("cell_char", cell_char, want.ch);
          if (cell_attr !== want.attr) flag_mismatch("cell_attr", cell_attr, want.attr);
        end
      end
    end
  end

  initial begin
    int kind;
    int n;
    int k;
    bit held;
    bit drained;
    held = 1'b0;
    drained = 1'b0;
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    func       <= FUNC_PUT;
    char_code  <= 8'h00;
    cell_index <= 11'd0;
    blank_screen();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (script[k])
      issue(script[k].f, script[k].c, script[k].i, script[k].typed,
            '{script[k].pos, script[k].ch, script[k].attr});

    while (beats_live < ITEMS) begin
      if (!held && beats_live >= 600) begin
        held = 1'b1;
        hold_req = 1'b1;
      end
      if (!drained && beats_live >= 1000) begin
        drained = 1'b1;
        in_valid <= 1'b0;
        while (expected_reports.size() > 0) @(posedge clk);
        burst_left = $urandom_range(1, 20);
      end
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        // a line of text, short or long enough to wrap, with reads mixed in
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 100) : $urandom_range(0, 20);
        for (k = 0; k < n; k++) begin
          if ($urandom_range(0, 3) == 0)
            issue(FUNC_READ, 8'($urandom), recent_cell(), 1'b0, '0);
          else
            issue(FUNC_PUT, 8'($urandom), 11'($urandom), 1'b0, '0);
        end
        issue(FUNC_PUT, NEWLINE_CODE, 11'($urandom), 1'b0, '0);
      end else if (kind < 70) begin
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++) issue(FUNC_PUT, NEWLINE_CODE, 11'($urandom), 1'b0, '0);
      end else if (kind < 88) begin
        n = $urandom_range(1, 8);
        for (k = 0; k < n; k++) issue(FUNC_READ, 8'($urandom), any_cell(), 1'b0, '0);
      end else if (kind < 91) begin
        issue(FUNC_CLEAR, 8'($urandom), 11'($urandom), 1'b0, '0);
      end else if (kind < 96) begin
        issue(FUNC_NONE, 8'($urandom), 11'($urandom), 1'b0, '0);
      end else begin
        issue(FUNC_READ, 8'($urandom), 11'($urandom_range(CELLS, 2047)), 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (expected_reports.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
